// File: src/bspline_curve_point_eval_macros.svh
// Assertion macros shared by the curve evaluator
`ifndef BSPLINE_CURVE_POINT_EVAL_MACROS_SVH
`define BSPLINE_CURVE_POINT_EVAL_MACROS_SVH
// implication checked on every clock, off during reset
`define BSP_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication
`define BSP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// File: src/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the B-spline curve point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package bsp_pkg;
    localparam int NumKnotsDef     = 16;
    localparam int MaxDegreeDef    = 7;
    localparam int FractionBitsDef = 12;
    localparam int PointDepth      = 16;
    localparam int SlotW           = 4;
    localparam int KnotW           = 16;
    localparam int CoordW          = 12;
    localparam int OutW            = 20;

    typedef enum logic [1:0] {
        OP_WR_POINT = 2'd0,
        OP_WR_KNOT  = 2'd1,
        OP_EVAL     = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FEW       = 2'd1,
        ST_RANGE     = 2'd2,
        ST_KNOTS_LOW = 2'd3
    } status_t;

    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_COUNT  = 1'b1;
endpackage
`default_nettype wire

// File: src/bsp_if.sv
// ----------------------------------------------------------------------------
// bsp_in_if / bsp_out_if / bsp_cfg_if
// Valid/ready channels of the curve evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
interface bsp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [3:0]  slot;
    logic signed [11:0] point_x;
    logic signed [11:0] point_y;
    logic [15:0] knot_value;
    logic [15:0] param_t;
    modport source (output valid, opcode, slot, point_x, point_y, knot_value, param_t,
                    input ready);
    modport sink (input valid, opcode, slot, point_x, point_y, knot_value, param_t,
                  output ready);
endinterface

interface bsp_out_if;
    logic        valid;
    logic        ready;
    logic signed [19:0] curve_x;
    logic signed [19:0] curve_y;
    logic [1:0]  status;
    modport source (output valid, curve_x, curve_y, status, input ready);
    modport sink (input valid, curve_x, curve_y, status, output ready);
endinterface

interface bsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [3:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/bspline_curve_point_eval.sv
// Sequence: a write or unused item goes to S_OUT once it is taken; an evaluation
//   first reads the whole knot table and runs its checks, then sets the level-0 basis
//   and walks each basis term with up to two live divisions (30-bit restoring divider),
//   then sums the weighted points and registers the result; the divider sets the time.
// Throughput: one item at a time; the next is taken the cycle after the result goes.
// Reset: asynchronous, active low; afterwards the knot table is refilled, and no item is taken meanwhile.
`default_nettype none
`include "bspline_curve_point_eval_macros.svh"
module bspline_curve_point_eval
    import bsp_pkg::*;
#(
    parameter int NumKnots     = NumKnotsDef,
    parameter int MaxDegree    = MaxDegreeDef,
    parameter int FractionBits = FractionBitsDef
) (
    input wire logic  clk,
    input wire logic  rst_n,
    bsp_in_if.sink    in_ch,
    bsp_out_if.source out_ch,
    bsp_cfg_if.sink   cfg
);
    logic [2:0] degree;
    logic [3:0] point_count;

    bsp_cfg u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg),
                   .degree(degree), .point_count(point_count));

    bsp_core #(.NumKnots(NumKnots), .MaxDegree(MaxDegree),
               .FractionBits(FractionBits)) u_core (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .degree(degree), .point_count(point_count));

    `BSP_ASSERT_IMPL(a_no_take, clk, rst_n, out_ch.valid, !in_ch.ready, "taken while held")
    `BSP_ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "drop")
    `BSP_ASSERT_IMPL(a_zero_x, clk, rst_n, out_ch.status != ST_OK, out_ch.curve_x == '0, "x err")
    `BSP_ASSERT_IMPL(a_zero_y, clk, rst_n, out_ch.status != ST_OK, out_ch.curve_y == '0, "y err")
endmodule
`default_nettype wire

// File: src/bsp_ram.sv
// ----------------------------------------------------------------------------
// bsp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bsp_ram #(
    parameter int Width = 16,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: src/bsp_div.sv
// ----------------------------------------------------------------------------
// bsp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bsp_div #(
    parameter int NumW = 40,
    parameter int DenW = 17
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [NumW-1:0] num,
    input  wire logic [DenW-1:0] den,
    output logic                 done,
    output logic      [NumW-1:0] quot
);
    localparam int CntW = $clog2(NumW + 1);
    logic [NumW-1:0] q_reg;
    logic [DenW:0]   rem_reg;
    logic [DenW-1:0] den_reg;
    logic [CntW-1:0] cnt_reg;
    logic            busy_reg;
    logic [DenW:0]   shifted;
    logic [DenW:0]   diff;

    always_comb
    begin
        shifted = {rem_reg[DenW-1:0], q_reg[NumW-1]};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(NumW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DenW])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[NumW-2:0], 1'b0};
            end
        end
    end

    assign quot = q_reg;
endmodule
`default_nettype wire

// File: src/bsp_core.sv
// ----------------------------------------------------------------------------
// bsp_core
// Sequencer: table writes, checks, Cox-de Boor walk and weighted sum.
// ----------------------------------------------------------------------------
`default_nettype none
module bsp_core
    import bsp_pkg::*;
#(
    parameter int NumKnots     = NumKnotsDef,
    parameter int MaxDegree    = MaxDegreeDef,
    parameter int FractionBits = FractionBitsDef
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bsp_in_if.sink    in_ch,
    bsp_out_if.source out_ch,
    input  wire logic [2:0] degree,
    input  wire logic [3:0] point_count
);
    localparam int KA  = $clog2(NumKnots);
    localparam int PA  = $clog2(PointDepth);
    localparam int BW  = FractionBits + 1;
    localparam int NW  = KnotW + 1 + BW;
    localparam int AccW = BW + CoordW + 5;
    localparam int Sh  = FractionBits - 8;
    localparam logic [BW-1:0] One = BW'(1) << FractionBits;
    localparam int DegW = 4;
    localparam logic [DegW-1:0] MaxD = DegW'(MaxDegree > 7 ? 7 : MaxDegree);

    typedef enum logic [3:0] {
        S_IDLE, S_KREQ, S_KWAIT, S_WB, S_CHK, S_L0,
        S_TA, S_DA, S_TB, S_DB, S_SUMREQ, S_SUMWAIT, S_SUMMUL, S_OUT
    } state_t;

    state_t state_reg;
    logic [KnotW-1:0] knots_reg [NumKnots];
    logic [BW-1:0]    basis_reg [NumKnots];
    logic [KA:0]      kidx_reg;
    logic [KnotW-1:0] t_reg;
    logic [DegW-1:0]  d_reg;
    logic [4:0]       last_reg;
    logic [3:0]       p_reg;
    logic [DegW-1:0]  n_reg;
    logic [KA:0]      j_reg;
    logic [BW:0]      v_reg;
    logic [NW-1:0]    num_reg;
    logic [KnotW:0]   den_reg;
    logic             div_start_reg;
    logic             div_done;
    logic [NW-1:0]    div_q;
    logic signed [AccW-1:0] ax_reg, ay_reg;
    logic signed [BW+CoordW:0] mx_reg, my_reg;
    logic             out_valid_reg;
    logic signed [OutW-1:0] ox_reg, oy_reg;
    logic [1:0]       st_reg;

    // knot RAM
    logic                 k_we;
    logic [KA-1:0]        k_waddr, k_raddr;
    logic [KnotW-1:0]     k_wdata, k_rdata;
    logic                 init_reg;
    logic [KA:0]          init_cnt_reg;
    // point RAM
    logic                 p_we;
    logic [PA-1:0]        p_raddr;
    logic [2*CoordW-1:0]  p_rdata;

    logic accept;
    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg && !init_reg;

    assign k_we    = init_reg || (accept && in_ch.opcode == OP_WR_KNOT
                                  && 32'(in_ch.slot) < NumKnots);
    assign k_waddr = init_reg ? init_cnt_reg[KA-1:0] : KA'(in_ch.slot);
    assign k_wdata = init_reg ? KnotW'(32'(init_cnt_reg) << 12) : in_ch.knot_value;
    assign k_raddr = kidx_reg[KA-1:0];
    assign p_we    = accept && in_ch.opcode == OP_WR_POINT;
    assign p_raddr = PA'(j_reg);

    bsp_ram #(.Width(KnotW), .Depth(NumKnots)) u_knot_ram (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata));

    bsp_ram #(.Width(2*CoordW), .Depth(PointDepth)) u_point_ram (
        .clk(clk), .we(p_we), .waddr(in_ch.slot),
        .wdata({in_ch.point_x, in_ch.point_y}),
        .raddr(p_raddr), .rdata(p_rdata));

    bsp_div #(.NumW(NW), .DenW(KnotW+1)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start_reg),
        .num(num_reg), .den(den_reg), .done(div_done), .quot(div_q));

    // term operands for the current (j, n)
    logic [KA:0] jn, jn1;
    logic [KnotW-1:0] ki, kin, ki1, kin1;
    logic signed [KnotW+1:0] spa, spb, nma, nmb;
    always_comb
    begin
        jn   = j_reg + (KA+1)'(n_reg);
        jn1  = jn + 1'b1;
        ki   = knots_reg[j_reg[KA-1:0]];
        ki1  = knots_reg[KA'(j_reg + 1'b1)];
        kin  = knots_reg[jn[KA-1:0]];
        kin1 = knots_reg[jn1[KA-1:0]];
        spa  = $signed({2'b0, kin}) - $signed({2'b0, ki});
        nma  = $signed({2'b0, t_reg}) - $signed({2'b0, ki});
        spb  = $signed({2'b0, kin1}) - $signed({2'b0, ki1});
        nmb  = $signed({2'b0, kin1}) - $signed({2'b0, t_reg});
        if (nma < 0) nma = '0;
        if (nma > spa) nma = spa;
        if (nmb < 0) nmb = '0;
        if (nmb > spb) nmb = spb;
    end

    // output conversion with floor shift and saturation
    function automatic logic signed [OutW-1:0] to_out(input logic signed [AccW-1:0] a);
        logic signed [AccW-1:0] r;
        r = a >>> Sh;
        if (r > AccW'(524287)) return OutW'(524287);
        if (r < -AccW'(524288)) return OutW'(-524288);
        return r[OutW-1:0];
    endfunction

    logic [DegW-1:0] d_eff;
    always_comb
    begin
        d_eff = {1'b0, degree};
        if (d_eff > MaxD) d_eff = MaxD;
        if (d_eff < DegW'(1)) d_eff = DegW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            init_reg      <= 1'b1;
            init_cnt_reg  <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            st_reg        <= ST_OK;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (init_reg)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
                if (init_cnt_reg == (KA+1)'(NumKnots - 1)) init_reg <= 1'b0;
            end
            if (out_valid_reg && out_ch.ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ox_reg <= '0; oy_reg <= '0; st_reg <= ST_OK;
                        t_reg  <= in_ch.param_t;
                        if (in_ch.opcode == OP_EVAL)
                        begin
                            d_reg    <= d_eff;
                            p_reg    <= point_count;
                            last_reg <= 5'(point_count) + 5'(d_eff);
                            kidx_reg <= '0;
                            state_reg <= S_KREQ;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_KREQ:
                begin
                    // read whole knot table into the working row
                    kidx_reg  <= kidx_reg + 1'b1;
                    state_reg <= S_KWAIT;
                end
                S_KWAIT:
                begin
                    knots_reg[KA'(kidx_reg - 1'b1)] <= k_rdata;
                    if (kidx_reg == (KA+1)'(NumKnots)) state_reg <= S_CHK;
                    else
                    begin
                        kidx_reg <= kidx_reg + 1'b1;
                    end
                end
                S_CHK:
                begin
                    if ({1'b0, d_reg} + 5'd1 > 5'(p_reg))
                    begin
                        st_reg <= ST_FEW; state_reg <= S_OUT;
                    end
                    else if (32'(last_reg) + 1 > NumKnots)
                    begin
                        st_reg <= ST_KNOTS_LOW; state_reg <= S_OUT;
                    end
                    else if (t_reg < knots_reg[KA'(d_reg)] || t_reg >= knots_reg[KA'(p_reg)])
                    begin
                        st_reg <= ST_RANGE; state_reg <= S_OUT;
                    end
                    else
                    begin
                        j_reg <= '0; state_reg <= S_L0;
                    end
                end
                S_L0:
                begin
                    basis_reg[j_reg[KA-1:0]] <= (t_reg >= ki && t_reg < ki1) ? One : '0;
                    if (j_reg + 1'b1 == (KA+1)'(last_reg))
                    begin
                        j_reg <= '0; n_reg <= DegW'(1); state_reg <= S_TA;
                    end
                    else j_reg <= j_reg + 1'b1;
                end
                S_TA:
                begin
                    v_reg <= '0;
                    if (spa > 0 && basis_reg[j_reg[KA-1:0]] != '0)
                    begin
                        num_reg <= NW'(nma[KnotW:0]) * NW'(basis_reg[j_reg[KA-1:0]]);
                        den_reg <= spa[KnotW:0];
                        div_start_reg <= 1'b1;
                        state_reg <= S_DA;
                    end
                    else state_reg <= S_TB;
                end
                S_DA:
                begin
                    if (div_done)
                    begin
                        v_reg <= (BW+1)'(div_q);
                        state_reg <= S_TB;
                    end
                end
                S_TB:
                begin
                    if (spb > 0 && basis_reg[KA'(j_reg + 1'b1)] != '0)
                    begin
                        num_reg <= NW'(nmb[KnotW:0]) * NW'(basis_reg[KA'(j_reg + 1'b1)]);
                        den_reg <= spb[KnotW:0];
                        div_start_reg <= 1'b1;
                        state_reg <= S_DB;
                    end
                    else state_reg <= S_WB;
                end
                S_DB:
                begin
                    if (div_done)
                    begin
                        v_reg <= v_reg + (BW+1)'(div_q);
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    // write back the clamped sum, then advance along the row
                    basis_reg[j_reg[KA-1:0]] <= (v_reg > (BW+1)'(One)) ? One : v_reg[BW-1:0];
                    if (j_reg + (KA+1)'(n_reg) + 1'b1 == (KA+1)'(last_reg))
                    begin
                        j_reg <= '0;
                        if (n_reg == d_reg)
                        begin
                            ax_reg <= '0; ay_reg <= '0; state_reg <= S_SUMREQ;
                        end
                        else
                        begin
                            n_reg <= n_reg + 1'b1; state_reg <= S_TA;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1; state_reg <= S_TA;
                    end
                end
                S_SUMREQ: state_reg <= S_SUMWAIT;
                S_SUMWAIT:
                begin
                    mx_reg <= $signed({1'b0, basis_reg[j_reg[KA-1:0]]})
                              * $signed(p_rdata[2*CoordW-1:CoordW]);
                    my_reg <= $signed({1'b0, basis_reg[j_reg[KA-1:0]]})
                              * $signed(p_rdata[CoordW-1:0]);
                    state_reg <= S_SUMMUL;
                end
                S_SUMMUL:
                begin
                    ax_reg <= ax_reg + AccW'(mx_reg);
                    ay_reg <= ay_reg + AccW'(my_reg);
                    if (j_reg + 1'b1 == (KA+1)'(p_reg))
                    begin
                        ox_reg <= to_out(ax_reg + AccW'(mx_reg));
                        oy_reg <= to_out(ay_reg + AccW'(my_reg));
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1; state_reg <= S_SUMREQ;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.curve_x = (st_reg == ST_OK) ? ox_reg : '0;
    assign out_ch.curve_y = (st_reg == ST_OK) ? oy_reg : '0;
    assign out_ch.status  = st_reg;
endmodule
`default_nettype wire

// File: src/bsp_cfg.sv
// ----------------------------------------------------------------------------
// bsp_cfg
// Configuration registers: degree and point count.
// ----------------------------------------------------------------------------
`default_nettype none
module bsp_cfg
    import bsp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bsp_cfg_if.sink   cfg,
    output logic [2:0] degree,
    output logic [3:0] point_count
);
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree      <= 3'd3;
            point_count <= 4'd0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_DEGREE) degree <= cfg.data[2:0];
            else point_count <= cfg.data;
        end
    end
endmodule
`default_nettype wire
